// ----- sv/dro_pair_decoder_keyon_tracker_assert.svh -----
// Assertion macros for the DRO pair decoder with key-on tracking.
// Included by modules that check their own logic; depends on nothing else.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef DRO_PAIR_DECODER_KEYON_TRACKER_ASSERT_SVH
`define DRO_PAIR_DECODER_KEYON_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define DPKT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DPKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DPKT_ASSERT_IMPL(lbl, ante, cons, msg)
`define DPKT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/dpkt_pkg.sv -----
// Package for the DRO pair decoder: field widths, register indexes,
// OPL key-on register constants and shared types. Depends on nothing.
package dpkt_pkg;

    localparam int CODE_W  = 8;
    localparam int VALUE_W = 8;
    localparam int ADDR_W  = 9;
    localparam int TIME_W  = 32;
    localparam int EVNUM_W = 32;
    localparam int CH_W    = 5;
    localparam int COUNT_W = 16;
    localparam int IDX_W   = 7;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_DELAY_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_DELAY_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODEMAP_LENGTH   = 2'd2;

    // Configuration reset values.
    localparam logic [CODE_W-1:0] SHORT_DELAY_RESET = 8'h00;
    localparam logic [CODE_W-1:0] LONG_DELAY_RESET  = 8'h01;
    localparam logic [CODE_W-1:0] CODEMAP_LEN_RESET = 8'h00;

    // Key-on registers are 0xB0..0xB8 in each bank; bit 5 of the value is key-on.
    localparam logic [3:0]      KEY_REG_HIGH_NIBBLE = 4'hB;
    localparam logic [3:0]      KEY_REG_LAST_LOW    = 4'h8;
    localparam int              KEY_ON_BIT          = 5;
    localparam logic [CH_W-1:0] SECOND_BANK_CH_BASE = 5'd9;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

    typedef struct packed {
        logic [CODE_W-1:0] short_delay_code;
        logic [CODE_W-1:0] long_delay_code;
        logic [CODE_W-1:0] codemap_length;
    } cfg_regs_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  reg_address;
        logic [VALUE_W-1:0] reg_value;
        logic [TIME_W-1:0]  timestamp;
        logic [EVNUM_W-1:0] event_number;
        logic               keyon_edge;
        logic [CH_W-1:0]    keyon_channel;
        logic [COUNT_W-1:0] keyon_total;
    } result_t;

endpackage

// ----- sv/dpkt_pair_if.sv -----
// Input channel of the DRO pair decoder: one code/value pair or codemap load.
// Depends on dpkt_pkg for field widths.
interface dpkt_pair_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [dpkt_pkg::CODE_W-1:0]  code;
    logic [dpkt_pkg::VALUE_W-1:0] value;

    modport source (output valid, op, code, value, input ready);
    modport sink   (input valid, op, code, value, output ready);
endinterface

// ----- sv/dpkt_event_if.sv -----
// Output channel of the DRO pair decoder: one OPL register event.
// Depends on dpkt_pkg for field widths.
interface dpkt_event_if;
    logic                          valid;
    logic                          ready;
    logic [dpkt_pkg::ADDR_W-1:0]   reg_address;
    logic [dpkt_pkg::VALUE_W-1:0]  reg_value;
    logic [dpkt_pkg::TIME_W-1:0]   timestamp;
    logic [dpkt_pkg::EVNUM_W-1:0]  event_number;
    logic                          keyon_edge;
    logic [dpkt_pkg::CH_W-1:0]     keyon_channel;
    logic [dpkt_pkg::COUNT_W-1:0]  keyon_total;

    modport source (output valid, reg_address, reg_value, timestamp, event_number,
                    keyon_edge, keyon_channel, keyon_total, input ready);
    modport sink   (input valid, reg_address, reg_value, timestamp, event_number,
                    keyon_edge, keyon_channel, keyon_total, output ready);
endinterface

// ----- sv/dpkt_cfg_if.sv -----
// Configuration write channel of the DRO pair decoder.
// Depends on dpkt_pkg for index and data widths.
interface dpkt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dpkt_pkg::CFG_IDX_W-1:0] index;
    logic [dpkt_pkg::CODE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/dpkt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dpkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/dro_pair_decoder_keyon_tracker.sv -----
// Top level of the DRO v2 pair decoder with OPL key-on tracking.
// Depends on dpkt_pkg, the dpkt_*_if interfaces, dpkt_ram and the assert header.
//
//   Channel    Dir   Transfer moves
//   -------    ---   -----------------------------------------------------
//   pair_in    in    op, code, value: a data pair or a codemap load
//   event_out  out   reg_address, reg_value, timestamp, event_number, key-on
//   cfg        in    index, data: write of one configuration register
//
// One input transfer is taken every cycle while the output flows. An item
// passes through the read stage (codemap RAM read, registered) and then the
// output register, from which its event leaves. Reset clears all control
// state and counters; the codemap is not cleared and needs no clearing
// pass. A stalled output holds the item in the read stage, and
// pair_in.ready falls until the output register drains.

`include "dro_pair_decoder_keyon_tracker_assert.svh"

module dro_pair_decoder_keyon_tracker #(
    parameter int NUM_CHANNELS  = 18,
    parameter int CODEMAP_DEPTH = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    dpkt_pair_if.sink       pair_in,
    dpkt_event_if.source    event_out,
    dpkt_cfg_if.sink        cfg
);

    localparam int AW  = (CODEMAP_DEPTH > 1) ? $clog2(CODEMAP_DEPTH) : 1;
    localparam int CIW = $clog2(NUM_CHANNELS);
    localparam logic [dpkt_pkg::CODE_W-1:0] DEPTH_LIMIT =
        dpkt_pkg::CODE_W'(CODEMAP_DEPTH);
    localparam logic [dpkt_pkg::CH_W-1:0] CH_LIMIT = dpkt_pkg::CH_W'(NUM_CHANNELS);

    // Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
    dpkt_pkg::cfg_regs_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_delay_code <= dpkt_pkg::SHORT_DELAY_RESET;
            cfg_reg.long_delay_code  <= dpkt_pkg::LONG_DELAY_RESET;
            cfg_reg.codemap_length   <= dpkt_pkg::CODEMAP_LEN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dpkt_pkg::CFG_SHORT_DELAY_CODE: cfg_reg.short_delay_code <= cfg.data;
                dpkt_pkg::CFG_LONG_DELAY_CODE:  cfg_reg.long_delay_code  <= cfg.data;
                dpkt_pkg::CFG_CODEMAP_LENGTH:   cfg_reg.codemap_length   <= cfg.data;
                default: ;
            endcase
        end
    end

    // Accept stage. A codemap load writes the RAM right away if its code is
    // below the codemap depth; a data pair starts the codemap read so that its
    // register number is ready when the pair reaches the read stage.
    logic                          in_fire;
    logic                          ram_we;
    logic                          ram_re;
    logic [dpkt_pkg::CODE_W-1:0]   ram_rdata;

    assign in_fire = pair_in.valid && pair_in.ready;
    assign ram_we  = in_fire && !pair_in.op && (pair_in.code < DEPTH_LIMIT);
    assign ram_re  = in_fire && pair_in.op;

    dpkt_ram #(
        .WIDTH (dpkt_pkg::CODE_W),
        .DEPTH (CODEMAP_DEPTH),
        .AW    (AW)
    ) u_codemap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pair_in.code[AW-1:0]),
        .wdata (pair_in.value),
        .re    (ram_re),
        .raddr (pair_in.code[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Read stage registers.
    logic                          s1_valid_reg;
    logic                          s1_op_reg;
    logic [dpkt_pkg::CODE_W-1:0]   s1_code_reg;
    logic [dpkt_pkg::VALUE_W-1:0]  s1_value_reg;
    logic                          s1_adv;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    dpkt_pkg::result_t             res_reg;

    // The read stage moves on when the output register is empty or being
    // drained in this cycle. Items that make no result move the same way.
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || event_out.ready);
    assign pair_in.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pair_in.ready)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg    <= pair_in.op;
            s1_code_reg  <= pair_in.code;
            s1_value_reg <= pair_in.value;
        end
    end

    // Decode of the item in the read stage. The short delay code wins when
    // both delay codes are equal.
    logic                          is_short;
    logic                          is_long;
    logic                          in_range;
    logic                          is_event;
    logic [dpkt_pkg::IDX_W-1:0]    map_idx;
    logic [dpkt_pkg::ADDR_W-1:0]   reg_addr;

    assign is_short = s1_op_reg && (s1_code_reg == cfg_reg.short_delay_code);
    assign is_long  = s1_op_reg && !is_short && (s1_code_reg == cfg_reg.long_delay_code);
    assign map_idx  = s1_code_reg[dpkt_pkg::IDX_W-1:0];
    assign in_range = ({1'b0, map_idx} < cfg_reg.codemap_length)
                   && ({1'b0, map_idx} < DEPTH_LIMIT);
    assign is_event = s1_op_reg && !is_short && !is_long && in_range;
    assign reg_addr = {s1_code_reg[dpkt_pkg::CODE_W-1], ram_rdata};

    // Running time and event count.
    logic [dpkt_pkg::TIME_W-1:0]   time_reg;
    logic [dpkt_pkg::TIME_W-1:0]   time_next;
    logic [dpkt_pkg::TIME_W-1:0]   delay_ms;
    logic [dpkt_pkg::VALUE_W:0]    value_plus_one;
    logic                          seen_event_reg;
    logic [dpkt_pkg::EVNUM_W-1:0]  event_cnt_reg;

    assign value_plus_one = {1'b0, s1_value_reg} + 9'd1;

    always_comb
    begin
        if (is_long)
        begin
            delay_ms = {15'd0, value_plus_one, 8'd0};
        end
        else
        begin
            delay_ms = dpkt_pkg::TIME_W'(value_plus_one);
        end
        time_next = time_reg;
        if (s1_adv && seen_event_reg && (is_short || is_long))
        begin
            time_next = time_reg + delay_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            seen_event_reg <= 1'b0;
            event_cnt_reg  <= '0;
        end
        else
        begin
            time_reg <= time_next;
            if (s1_adv && is_event)
            begin
                seen_event_reg <= 1'b1;
                event_cnt_reg  <= event_cnt_reg + 32'd1;
            end
        end
    end

    // Key-on tracking on registers 0xB0..0xB8 of both banks. The second bank
    // maps to channels 9 and up; channels from NUM_CHANNELS up are not tracked.
    logic                          key_reg_hit;
    logic [dpkt_pkg::CH_W-1:0]     ch_full;
    logic                          tracked;
    logic [CIW-1:0]                ch_idx;
    logic                          key_on;
    logic                          held_sel;
    logic [dpkt_pkg::COUNT_W-1:0]  count_sel;
    logic [dpkt_pkg::COUNT_W-1:0]  count_new;
    logic                          key_edge;
    logic [NUM_CHANNELS-1:0]       key_held_reg;
    logic [dpkt_pkg::COUNT_W-1:0]  keyon_cnt_reg [NUM_CHANNELS];

    assign key_reg_hit = (ram_rdata[7:4] == dpkt_pkg::KEY_REG_HIGH_NIBBLE)
                      && (ram_rdata[3:0] <= dpkt_pkg::KEY_REG_LAST_LOW);
    assign ch_full = {1'b0, ram_rdata[3:0]}
                   + (s1_code_reg[dpkt_pkg::CODE_W-1] ? dpkt_pkg::SECOND_BANK_CH_BASE
                                                      : dpkt_pkg::CH_W'(0));
    assign tracked = is_event && key_reg_hit && (ch_full < CH_LIMIT);
    assign ch_idx  = ch_full[CIW-1:0];
    assign key_on  = s1_value_reg[dpkt_pkg::KEY_ON_BIT];

    always_comb
    begin
        held_sel  = 1'b0;
        count_sel = '0;
        if (tracked)
        begin
            held_sel  = key_held_reg[ch_idx];
            count_sel = keyon_cnt_reg[ch_idx];
        end
    end

    assign key_edge  = tracked && key_on && !held_sel;
    assign count_new = (count_sel == dpkt_pkg::COUNT_MAX) ? count_sel
                                                          : count_sel + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_held_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                keyon_cnt_reg[i] <= '0;
            end
        end
        else if (s1_adv && tracked)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (ch_idx == CIW'(i))
                begin
                    key_held_reg[i] <= key_on;
                    if (key_edge)
                    begin
                        keyon_cnt_reg[i] <= count_new;
                    end
                end
            end
        end
    end

    // Output register. It takes a new event while the previous one is being
    // transferred, so back-to-back events flow without a bubble.
    assign out_valid_next = (s1_adv && is_event) ? 1'b1
                          : (event_out.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && is_event)
        begin
            res_reg.reg_address   <= reg_addr;
            res_reg.reg_value     <= s1_value_reg;
            res_reg.timestamp     <= time_reg;
            res_reg.event_number  <= event_cnt_reg;
            res_reg.keyon_edge    <= key_edge;
            res_reg.keyon_channel <= key_edge ? ch_full : '0;
            res_reg.keyon_total   <= key_edge ? count_new : '0;
        end
    end

    assign event_out.valid         = out_valid_reg;
    assign event_out.reg_address   = res_reg.reg_address;
    assign event_out.reg_value     = res_reg.reg_value;
    assign event_out.timestamp     = res_reg.timestamp;
    assign event_out.event_number  = res_reg.event_number;
    assign event_out.keyon_edge    = res_reg.keyon_edge;
    assign event_out.keyon_channel = res_reg.keyon_channel;
    assign event_out.keyon_total   = res_reg.keyon_total;

    // Checks on the decoder's own bookkeeping.
    `DPKT_ASSERT_IMPL(a_time_idle_before_event, !seen_event_reg, time_reg == '0, "time moved before first event")
    `DPKT_ASSERT_NEXT(a_event_count_step, s1_adv && is_event, event_cnt_reg == $past(event_cnt_reg) + 32'd1, "event count did not step")
    `DPKT_ASSERT_IMPL(a_edge_fields, out_valid_reg && res_reg.keyon_edge, (res_reg.keyon_total != '0) && (res_reg.keyon_channel < CH_LIMIT), "bad key-on fields")
    `DPKT_ASSERT_IMPL(a_no_edge_zero, out_valid_reg && !res_reg.keyon_edge, (res_reg.keyon_total == '0) && (res_reg.keyon_channel == '0), "key-on fields set without edge")
    `DPKT_ASSERT_IMPL(a_stall_holds_item, !pair_in.ready, s1_valid_reg && out_valid_reg, "input stalled with room to move")

endmodule
